// ----- sv/sem_pkg.sv -----
`default_nettype none
package sem_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int DIM_W         = 15;   // width/height/position arithmetic
  localparam int COL_MAX_W     = 14;   // column index, widest parameter setting
  localparam int PIX_W         = 16;
  localparam int MAG_W         = 19;
  localparam int POS_W         = 12;
  localparam int CFG_W         = 13;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;  // paddr[2] selects the register
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Work handed from the front end to the compute back end
  typedef struct packed {
    logic                 is_pix;
    logic [PIX_W-1:0]     pix;
    logic [COL_MAX_W-1:0] col;
    logic                 emit;
    logic                 border;
    logic [POS_W-1:0]     x;
    logic [POS_W-1:0]     y;
    logic                 last;
  } sem_cmd_t;

endpackage
`default_nettype wire

// ----- sv/sem_front.sv -----
`default_nettype none
module sem_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           take,
  input  wire                           req_type,
  input  wire  [sem_pkg::PIX_W-1:0]     pixel_value,
  input  wire  [sem_pkg::DIM_W-1:0]     w_eff,
  input  wire  [sem_pkg::DIM_W-1:0]     h_eff,
  output logic                          push,
  output sem_pkg::sem_cmd_t             cmd
);
  import sem_pkg::*;

  logic [DIM_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [DIM_W-1:0] ex_r, ex_nxt, ey_r, ey_nxt, pend_r, pend_nxt;

  always_comb begin
    logic [DIM_W-1:0] c, r, x, y, p;
    c = col_r;
    r = row_r;
    x = ex_r;
    y = ey_r;
    p = pend_r;
    push = 1'b0;
    cmd = '0;
    cmd.pix = pixel_value;
    if (c >= w_eff) begin
      c = '0;
      r = r + 1'b1;
    end
    if (req_type == REQ_DRAIN) begin
      if (!(r < h_eff) && p != '0) begin
        push = 1'b1;
        cmd.emit = 1'b1;
        cmd.last = (p == DIM_W'(1));
      end
    end else begin
      push = 1'b1;
      cmd.is_pix = 1'b1;
      if (r >= h_eff) begin
        c = '0; r = '0; x = '0; y = '0; p = '0;
      end
      cmd.col = c[COL_MAX_W-1:0];
      p = p + 1'b1;
      c = c + 1'b1;
      if (c >= w_eff) begin
        c = '0;
        r = r + 1'b1;
      end
      if (p > w_eff + 1'b1) cmd.emit = 1'b1;
    end
    if (cmd.emit) begin
      cmd.x = x[POS_W-1:0];
      cmd.y = y[POS_W-1:0];
      cmd.border = !(x != '0 && y != '0 && x < w_eff - 1'b1 && y < h_eff - 1'b1);
      p = p - 1'b1;
      if (x + 1'b1 >= w_eff) begin
        x = '0;
        y = y + 1'b1;
      end else begin
        x = x + 1'b1;
      end
      // frame fully drained: start over
      if (req_type == REQ_DRAIN && p == '0) begin
        c = '0; r = '0; x = '0; y = '0;
      end
    end
    col_nxt  = take ? c : col_r;
    row_nxt  = take ? r : row_r;
    ex_nxt   = take ? x : ex_r;
    ey_nxt   = take ? y : ey_r;
    pend_nxt = take ? p : pend_r;
    push     = push & take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; ex_r <= '0; ey_r <= '0; pend_r <= '0;
    end else begin
      col_r <= col_nxt; row_r <= row_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sem_fifo.sv -----
`default_nettype none
module sem_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  sem_pkg::sem_cmd_t   din,
  output logic                full,
  input  wire                 pop,
  output sem_pkg::sem_cmd_t   dout,
  output logic                avail
);
  import sem_pkg::*;

  sem_cmd_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && avail) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && avail);
    end
  end

endmodule
`default_nettype wire

// ----- sv/sem_back.sv -----
`default_nettype none
module sem_back #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cmd_avail,
  input  sem_pkg::sem_cmd_t           cmd_in,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [sem_pkg::MAG_W-1:0]   out_mag,
  output logic [sem_pkg::POS_W-1:0]   out_xpos,
  output logic [sem_pkg::POS_W-1:0]   out_ypos,
  output logic                        out_last
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = 2 * MAG_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_GRAD = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;
  localparam logic [2:0] S_ROOT = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]       st_r;
  sem_cmd_t         cmd_r;
  logic [PIX_W-1:0] line_a [MAX_WIDTH];
  logic [PIX_W-1:0] line_b [MAX_WIDTH];
  logic [PIX_W-1:0] top_q, mid_q;
  logic [PIX_W-1:0] win_r [3][3];
  logic [MAG_W-1:0] gx_r, gy_r, mag_r;
  logic [SW-1:0]    sqx_r, sqy_r, rem_r, res_r, bit_r;
  logic             ov_r;
  logic [CW-1:0]    idx;

  logic [PIX_W+1:0] pl, pr, pt, pb;
  logic signed [PIX_W+3:0] dx, dy;
  logic [MAG_W-1:0] ax, ay;
  logic [SW-1:0]    trial, res_nxt, rem_nxt;
  logic             load_out;

  assign idx      = cmd_r.col[CW-1:0];
  assign cmd_pop  = (st_r == S_IDLE) && cmd_avail;
  assign load_out = (st_r == S_DONE) && (!ov_r || out_ready);
  assign out_valid = ov_r;

  // Sobel sums: left/right columns and top/bottom rows, weights 1,2,1
  always_comb begin
    pl = (PIX_W+2)'(win_r[0][0]) + {1'b0, win_r[1][0], 1'b0} + (PIX_W+2)'(win_r[2][0]);
    pr = (PIX_W+2)'(win_r[0][2]) + {1'b0, win_r[1][2], 1'b0} + (PIX_W+2)'(win_r[2][2]);
    pt = (PIX_W+2)'(win_r[0][0]) + {1'b0, win_r[0][1], 1'b0} + (PIX_W+2)'(win_r[0][2]);
    pb = (PIX_W+2)'(win_r[2][0]) + {1'b0, win_r[2][1], 1'b0} + (PIX_W+2)'(win_r[2][2]);
    dx = signed'({2'b00, pr}) - signed'({2'b00, pl});
    dy = signed'({2'b00, pb}) - signed'({2'b00, pt});
    ax = dx[PIX_W+3] ? MAG_W'(-dx) : MAG_W'(dx);
    ay = dy[PIX_W+3] ? MAG_W'(-dy) : MAG_W'(dy);
  end

  // One step of the digit-by-digit square root
  always_comb begin
    trial = res_r + bit_r;
    if (rem_r >= trial) begin
      rem_nxt = rem_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      rem_nxt = rem_r;
      res_nxt = res_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_RD: begin
        top_q <= line_b[idx];
        mid_q <= line_a[idx];
      end
      S_WR: begin
        line_a[idx] <= cmd_r.pix;
        line_b[idx] <= mid_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (cmd_avail) cmd_r <= cmd_in;
      S_GRAD: begin
        gx_r <= ax;
        gy_r <= ay;
      end
      S_SQR: begin
        sqx_r <= SW'(gx_r) * SW'(gx_r);
        sqy_r <= SW'(gy_r) * SW'(gy_r);
      end
      S_SUM: begin
        rem_r <= sqx_r + sqy_r;
        res_r <= '0;
        bit_r <= SW'(1) << (SW - 2);
      end
      S_ROOT: begin
        rem_r <= rem_nxt;
        res_r <= res_nxt;
        bit_r <= bit_r >> 2;
        mag_r <= res_nxt[MAG_W-1:0];
      end
      default: ;
    endcase
    if (st_r == S_IDLE || st_r == S_WR) mag_r <= '0;
    if (load_out) begin
      out_mag  <= mag_r;
      out_xpos <= cmd_r.x;
      out_ypos <= cmd_r.y;
      out_last <= cmd_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win_r[r][c] <= '0;
      end
    end else begin
      if (load_out) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_avail) begin
            if (cmd_in.is_pix) st_r <= S_RD;
            else if (cmd_in.border) st_r <= S_DONE;
            else st_r <= S_GRAD;
          end
        end
        S_RD: st_r <= S_WR;
        S_WR: begin
          // advance the window one column
          for (int r = 0; r < 3; r++) begin
            win_r[r][0] <= win_r[r][1];
            win_r[r][1] <= win_r[r][2];
          end
          win_r[0][2] <= top_q;
          win_r[1][2] <= mid_q;
          win_r[2][2] <= cmd_r.pix;
          if (!cmd_r.emit) st_r <= S_IDLE;
          else if (cmd_r.border) st_r <= S_DONE;
          else st_r <= S_GRAD;
        end
        S_GRAD: st_r <= S_SQR;
        S_SQR:  st_r <= S_SUM;
        S_SUM:  st_r <= S_ROOT;
        S_ROOT: if (bit_r == SW'(1)) st_r <= S_DONE;
        S_DONE: if (load_out) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/sobel_edge_magnitude.sv -----
`default_nettype none
// Channel   Dir  Handshake                 Payload
// in_*      in   in_tvalid / in_tready     tdata: pixel_value; tuser: req_type
// out_*     out  out_tvalid / out_tready   tdata: magnitude, out_x, out_y; tlast: frame_last
// cfg_*     in   APB psel/penable/pready   frame_width @0x0, frame_height @0x4
//
// The front end takes one request a cycle while its two-entry queue has room.
// The back end takes a pixel request that yields no result through IDLE, RD and
// WR, and one with an interior result on through GRAD, SQR, SUM, ROOT and DONE:
// the square root unit retires one result bit per cycle (19 steps). A border
// result skips to DONE from WR after a pixel request, from IDLE after a drain.
// Reset (rst_n, synchronous) clears counters, window and queue; line stores are
// not cleared. A stalled output holds the back end; the queue then fills and
// drops in_tready.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [15:0]  in_tdata,    // [15:0] pixel_value
  input  wire  [0:0]   in_tuser,    // [0] req_type
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [47:0]  out_tdata,   // [18:0] magnitude, [30:19] out_x, [42:31] out_y, zero pad
  output logic         out_tlast,
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [2:0]   cfg_paddr,
  input  wire  [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import sem_pkg::*;

  localparam logic [DIM_W-1:0] MAXW = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAXH = DIM_W'(MAX_HEIGHT);

  logic [CFG_W-1:0] fw_r, fh_r;
  logic [DIM_W-1:0] w_eff, h_eff, fw_x, fh_x;
  logic             take, push, full, pop, avail;
  sem_cmd_t         cmd_f, cmd_b;
  logic [MAG_W-1:0] mag;
  logic [POS_W-1:0] xo, yo;

  // Register file: write on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FRAME_HEIGHT) ? 32'(fh_r) : 32'(fw_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == REG_FRAME_WIDTH) fw_r <= cfg_pwdata[CFG_W-1:0];
      else fh_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // Clamp frame size to the supported range
  always_comb begin
    fw_x = DIM_W'(fw_r);
    fh_x = DIM_W'(fh_r);
    if (fw_x < DIM_W'(3)) w_eff = DIM_W'(3);
    else if (fw_x > MAXW) w_eff = MAXW;
    else w_eff = fw_x;
    if (fh_x < DIM_W'(3)) h_eff = DIM_W'(3);
    else if (fh_x > MAXH) h_eff = MAXH;
    else h_eff = fh_x;
  end

  assign in_tready = !full;
  assign take      = in_tvalid && in_tready;

  sem_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .req_type(in_tuser[0]),
    .pixel_value(in_tdata), .w_eff(w_eff), .h_eff(h_eff),
    .push(push), .cmd(cmd_f)
  );

  sem_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .din(cmd_f), .full(full),
    .pop(pop), .dout(cmd_b), .avail(avail)
  );

  sem_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_avail(avail), .cmd_in(cmd_b), .cmd_pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_mag(mag),
    .out_xpos(xo), .out_ypos(yo), .out_last(out_tlast)
  );

  assign out_tdata = {5'b0, yo, xo, mag};

endmodule
`default_nettype wire

// ----- sim/sem_checker.sv -----
`timescale 1ns / 1ps
module sem_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire [15:0]  in_tdata,
  input  wire [0:0]   in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire [47:0]  out_tdata,
  input  wire         out_tlast,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire [2:0]   cfg_paddr,
  input  wire [31:0]  cfg_pwdata,
  input  wire         cfg_pready,
  output int          fail_count,
  output int          owed_results
);
  import sem_pkg::*;

  typedef struct {
    logic [MAG_W-1:0] mag;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             last;
  } edge_px_t;

  edge_px_t expected_px[$];

  logic [CFG_W-1:0] width_reg, height_reg;
  logic [PIX_W-1:0] line_prev [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] line_prev2[MAX_WIDTH_DEF];
  longint win[3][3];
  int unsigned col_in, row_in, emit_x, emit_y, px_owed;

  assign owed_results = expected_px.size();

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
    int unsigned d;
    d = v;
    if (d < 3) d = 3;
    if (d > hi) d = hi;
    return d;
  endfunction

  // floor square root by binary search on the result
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd1 << 21;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [MAG_W-1:0] gradient_mag();
    longint gx, gy;
    longint unsigned ax, ay, r;
    gx = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
    gy = (win[2][0] + 2 * win[2][1] + win[2][2]) - (win[0][0] + 2 * win[0][1] + win[0][2]);
    ax = gx < 0 ? -gx : gx;
    ay = gy < 0 ? -gy : gy;
    if (ax >= (64'd1 << 19) || ay >= (64'd1 << 19)) return '1;
    r = floor_root(ax * ax + ay * ay);
    return r > 524287 ? '1 : r[MAG_W-1:0];
  endfunction

  task automatic queue_result(bit last);
    int unsigned w, h;
    edge_px_t e;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    e.mag = '0;
    if (emit_x != 0 && emit_y != 0 && emit_x < w - 1 && emit_y < h - 1) e.mag = gradient_mag();
    e.x = emit_x[POS_W-1:0];
    e.y = emit_y[POS_W-1:0];
    e.last = last;
    expected_px.push_back(e);
    px_owed--;
    if (emit_x + 1 >= w) begin
      emit_x = 0;
      emit_y++;
    end else begin
      emit_x++;
    end
  endtask

  task automatic clear_position();
    col_in = 0;
    row_in = 0;
    emit_x = 0;
    emit_y = 0;
    px_owed = 0;
  endtask

  task automatic predict_request(logic req, logic [PIX_W-1:0] pix);
    int unsigned w, h, col;
    logic [PIX_W-1:0] top, mid;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (req == REQ_DRAIN) begin
      // drains count only after the frame's last pixel
      if (row_in < h || px_owed == 0) return;
      queue_result(px_owed == 1);
      if (px_owed == 0) clear_position();
      return;
    end
    if (row_in >= h) clear_position();
    col = col_in < MAX_WIDTH_DEF ? col_in : 0;
    top = line_prev2[col];
    mid = line_prev[col];
    line_prev2[col] = mid;
    line_prev[col] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;
    px_owed++;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (px_owed > w + 1) queue_result(1'b0);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("%0t checker: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    edge_px_t e;
    if (!rst_n) begin
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] = 0;
      clear_position();
      expected_px.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_FRAME_WIDTH) width_reg = cfg_pwdata[CFG_W-1:0];
        else height_reg = cfg_pwdata[CFG_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        if (expected_px.size() == 0) begin
          report("unexpected result, x", out_tdata[30:19], -1);
        end else begin
          e = expected_px.pop_front();
          if (out_tdata[18:0] !== e.mag) report("magnitude", out_tdata[18:0], e.mag);
          if (out_tdata[30:19] !== e.x) report("out_x", out_tdata[30:19], e.x);
          if (out_tdata[42:31] !== e.y) report("out_y", out_tdata[42:31], e.y);
          if (out_tdata[47:43] !== 5'd0) report("pad bits", out_tdata[47:43], 0);
          if (out_tlast !== e.last) report("frame_last", out_tlast, e.last);
        end
      end
      if (in_tvalid && in_tready) predict_request(in_tuser[0], in_tdata);
    end
  end
endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import sem_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [15:0] pixel_value
  logic [0:0]  in_tuser = '0;    // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [47:0] out_tdata;        // [18:0] magnitude, [30:19] out_x, [42:31] out_y
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int owed_results;
  int requests_sent = 0;
  bit send_burst = 1'b0;       // sender offers back to back while set

  always #5 clk = ~clk;

  sobel_edge_magnitude uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  sem_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .owed_results
  );

  // Hard stop well beyond the slowest legal run.
  initial begin
    #8ms;
    $display("tb_top: FAIL");
    $finish;
  end

  // Result side: stall a random number of cycles after each accepted result.
  // Once, hold off for a long stretch so the block backs up into in_tready.
  initial begin
    int taken;
    int hold;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        taken++;
        if (taken % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
        hold = quiet ? 0 : $urandom_range(0, 18);
        if (taken == 30) hold = 600;
        if (hold > 0) begin
          out_tready <= 1'b0;
          repeat (hold) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Offer one request, wait for its handshake, then idle a random gap unless send_burst is set.
  task automatic send_request(logic req, logic [15:0] pix);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= pix;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    gap = send_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Drop valid, wait for every owed result, then let queued no-result work finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_results != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [15:0] random_pixel();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // One frame: raster pixels with stray drains mixed in, then the drain tail.
  // Cut the tail short now and then so the next frame drops owed results.
  task automatic run_frame(int w, int h);
    int tail;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 19) == 0) send_request(REQ_DRAIN, 16'($urandom));
      send_request(REQ_PIXEL, random_pixel());
    end
    tail = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w) : w + 1;
    for (int i = 0; i < tail; i++) send_request(REQ_DRAIN, 16'($urandom));
    if ($urandom_range(0, 3) == 0) send_request(REQ_DRAIN, 16'($urandom));
  endtask

  initial begin
    int w, h;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frame from out-of-range sizes (clamp up to 3x3).
    write_reg(REG_FRAME_WIDTH, 32'd0);
    write_reg(REG_FRAME_HEIGHT, 32'd1);
    send_request(REQ_DRAIN, 16'h1234);         // drain with nothing owed
    for (int i = 0; i < 9; i++)
      send_request(REQ_PIXEL, (i % 2) ? 16'hFFFF : 16'h0000);
    for (int i = 0; i < 5; i++) send_request(REQ_DRAIN, 16'hFFFF);
    // Full-scale step, then a frame cut short by a new pixel.
    for (int i = 0; i < 9; i++)
      send_request(REQ_PIXEL, (i % 3 == 2) ? 16'hFFFF : 16'h0000);
    send_request(REQ_DRAIN, 16'h0);
    send_request(REQ_PIXEL, 16'h8001);
    settle();

    // Random frames, mostly small.
    while (requests_sent < 820) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : w);
      if (cfg_pwdata < 3) w = 3;
      write_reg(REG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : h);
      if (cfg_pwdata < 3) h = 3;
      send_burst = ($urandom_range(0, 3) == 0);
      for (int f = $urandom_range(1, 2); f > 0; f--) run_frame(w, h);
      settle();
    end

    // Largest sizes (clamp down to 4096): pixels and one drain, no result expected.
    send_burst = 1'b0;
    write_reg(REG_FRAME_WIDTH, 32'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 32'h1FFF);
    for (int i = 0; i < 60; i++) send_request(REQ_PIXEL, random_pixel());
    send_request(REQ_DRAIN, 16'h0);
    settle();

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/sem_pkg.sv
sv/sem_front.sv
sv/sem_fifo.sv
sv/sem_back.sv
sv/sobel_edge_magnitude.sv
sim/sem_checker.sv
sim/tb_top.sv
